// ===== design/tst_pkg.sv =====
// shared types and constants for the timestamped sample table
// holds request, result and stored entry layouts, codes and the controller states
// no dependencies
package tst_pkg;

	localparam int TableDepth = 64;

	// operation codes
	localparam logic [2:0] OP_INSERT  = 3'd0;
	localparam logic [2:0] OP_DELETE  = 3'd1;
	localparam logic [2:0] OP_MAX     = 3'd2;
	localparam logic [2:0] OP_MIN     = 3'd3;
	localparam logic [2:0] OP_BY_TIME = 3'd4;
	localparam logic [2:0] OP_BY_TEMP = 3'd5;

	// result status codes
	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_FULL     = 3'd1;
	localparam logic [2:0] STS_NO_ID    = 3'd2;
	localparam logic [2:0] STS_NO_MATCH = 3'd3;
	localparam logic [2:0] STS_IDS_OUT  = 3'd4;

	localparam logic [15:0] MaxId = 16'hFFFF;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [11:0]        year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic signed [15:0] temperature;
		logic [15:0]        record_id_in;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [15:0]        out_id;
		logic signed [15:0] out_temperature;
		logic [11:0]        out_year;
		logic [3:0]         out_month;
		logic [4:0]         out_day;
		logic [4:0]         out_hour;
		logic [5:0]         out_minute;
		logic               last;
	} rsp_t;

	// one stored sample, 64 bits
	typedef struct packed {
		logic [5:0]         minute;
		logic [4:0]         hour;
		logic [4:0]         day;
		logic [3:0]         month;
		logic [11:0]        year;
		logic signed [15:0] temperature;
		logic [15:0]        id;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_PLACE,
		S_EMIT
	} state_t;

endpackage

// ===== design/timestamped_sample_table.sv =====
// Timestamped sample table, top level.
// Depends on tst_pkg and tst_ram.
//
// Requests come in on cmd (cmd_valid / cmd_stall), results leave on rsp
// (rsp_valid / rsp_stall); a request is taken when valid is high and stall low.
// Each request gives one result, except a readout, which gives one result per
// stored entry (or one no-match result when the table is empty); the final
// result of a request has last set. Opcodes 6 and 7 are taken and give nothing.
// Samples live in one memory of TABLE_DEPTH entries, read one entry a cycle
// (a readout by time waits while rsp_stall holds it) through its registered
// read port, so requests walk the table (n = entries): max / min query, delete,
// readout by time: one scan; insert: id and position scan, then the move down;
// readout by temperature: n passes, one result a pass.
// cmd_stall is high from the cycle after a request is taken until it is done.
// Results go through one output register; while rsp_stall holds it a readout
// by time pauses its walk, other requests wait to load it, and nothing is
// lost. Reset clears the entry count, the state and the output valid; memory
// contents are not cleared, entries past the count are never read.
module timestamped_sample_table #(
	parameter int TABLE_DEPTH = tst_pkg::TableDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  tst_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tst_pkg::rsp_t rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	tst_pkg::state_t st_q, st_d;

	tst_pkg::cmd_t   cmd_q;
	tst_pkg::rsp_t   pend_q;
	tst_pkg::rsp_t   rsp_q;
	logic            rsp_valid_q;

	logic [CW-1:0]   n_q;
	logic [CW-1:0]   rd_q;
	logic [AW-1:0]   di_q;
	logic            dv_q;
	logic [CW-1:0]   kept_q;
	logic            hit_q;
	logic [15:0]     maxid_q;
	logic [CW-1:0]   pos_q;
	logic            pos_found_q;
	logic            found_q;
	tst_pkg::entry_t best_q;
	logic [AW-1:0]   best_idx_q;
	logic [CW-1:0]   pass_q;
	logic            have_last_q;
	logic signed [15:0] last_t_q;
	logic [AW-1:0]   last_idx_q;
	tst_pkg::entry_t new_q;

	logic            re;
	logic [AW-1:0]   raddr;
	logic            we;
	logic [AW-1:0]   waddr;
	tst_pkg::entry_t wdata;
	logic [63:0]     rdata_raw;
	tst_pkg::entry_t rdata;

	logic            out_free;
	logic            load_out;
	tst_pkg::rsp_t   out_d;
	logic            cons;
	logic            rd_go;
	logic            sh_go;
	logic            scan_done;
	logic            shift_done;
	logic            cmd_take;

	function automatic tst_pkg::rsp_t to_rsp(tst_pkg::entry_t e, logic [2:0] sts,
			logic lst);
		tst_pkg::rsp_t r;
		r.status          = sts;
		r.out_id          = e.id;
		r.out_temperature = e.temperature;
		r.out_year        = e.year;
		r.out_month       = e.month;
		r.out_day         = e.day;
		r.out_hour        = e.hour;
		r.out_minute      = e.minute;
		r.last            = lst;
		return r;
	endfunction

	function automatic logic [31:0] time_key(tst_pkg::entry_t e);
		return {e.year, e.month, e.day, e.hour, e.minute};
	endfunction

	// submitted sample as an entry with id 0
	function automatic tst_pkg::entry_t cmd_entry(tst_pkg::cmd_t c);
		tst_pkg::entry_t e;
		e.id          = 16'd0;
		e.temperature = c.temperature;
		e.year        = c.year;
		e.month       = c.month;
		e.day         = c.day;
		e.hour        = c.hour;
		e.minute      = c.minute;
		return e;
	endfunction

	// same entry with its id replaced
	function automatic tst_pkg::entry_t with_id(tst_pkg::entry_t e, logic [15:0] id);
		tst_pkg::entry_t r;
		r    = e;
		r.id = id;
		return r;
	endfunction

	tst_ram #(
		.WIDTH(64),
		.DEPTH(TABLE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	assign rdata = tst_pkg::entry_t'(rdata_raw);

	// handshake and walk control
	assign cmd_stall = (st_q != tst_pkg::S_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign cons  = (st_q == tst_pkg::S_SCAN) && dv_q
		&& ((cmd_q.opcode != tst_pkg::OP_BY_TIME) || out_free);
	assign rd_go = (st_q == tst_pkg::S_SCAN) && (!dv_q || cons) && (rd_q < n_q);
	assign sh_go = (st_q == tst_pkg::S_SHIFT) && (rd_q > pos_q);
	assign scan_done  = (rd_q == n_q) && !dv_q;
	assign shift_done = (rd_q == pos_q) && !dv_q;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			tst_pkg::S_IDLE: begin
				if (cmd_take) begin
					case (cmd.opcode)
						tst_pkg::OP_INSERT: begin
							st_d = (n_q == CW'(TABLE_DEPTH)) ? tst_pkg::S_EMIT
								: tst_pkg::S_SCAN;
						end
						tst_pkg::OP_DELETE, tst_pkg::OP_MAX, tst_pkg::OP_MIN: begin
							st_d = tst_pkg::S_SCAN;
						end
						tst_pkg::OP_BY_TIME, tst_pkg::OP_BY_TEMP: begin
							st_d = (n_q == '0) ? tst_pkg::S_EMIT : tst_pkg::S_SCAN;
						end
						default: st_d = tst_pkg::S_IDLE;
					endcase
				end
			end
			tst_pkg::S_SCAN: begin
				if (scan_done) begin
					case (cmd_q.opcode)
						tst_pkg::OP_INSERT:  st_d = tst_pkg::S_DECIDE;
						tst_pkg::OP_BY_TIME: st_d = tst_pkg::S_IDLE;
						default:             st_d = tst_pkg::S_EMIT;
					endcase
				end
			end
			tst_pkg::S_DECIDE: begin
				st_d = ((n_q != '0) && (maxid_q == tst_pkg::MaxId)) ? tst_pkg::S_EMIT
					: tst_pkg::S_SHIFT;
			end
			tst_pkg::S_SHIFT: begin
				if (shift_done) begin
					st_d = tst_pkg::S_PLACE;
				end
			end
			tst_pkg::S_PLACE: begin
				st_d = tst_pkg::S_EMIT;
			end
			tst_pkg::S_EMIT: begin
				if (out_free) begin
					st_d = ((cmd_q.opcode == tst_pkg::OP_BY_TEMP) && (n_q != '0)
						&& (pass_q != n_q - CW'(1))) ? tst_pkg::S_SCAN : tst_pkg::S_IDLE;
				end
			end
			default: st_d = tst_pkg::S_IDLE;
		endcase
	end

	// memory ports and output load
	always_comb begin
		re       = 1'b0;
		raddr    = '0;
		we       = 1'b0;
		waddr    = '0;
		wdata    = rdata;
		load_out = 1'b0;
		out_d    = pend_q;
		case (st_q)
			tst_pkg::S_SCAN: begin
				re    = rd_go;
				raddr = rd_q[AW-1:0];
				if (cons && (cmd_q.opcode == tst_pkg::OP_DELETE)
						&& (rdata.id != cmd_q.record_id_in)) begin
					we    = 1'b1;
					waddr = kept_q[AW-1:0];
				end
				if (cons && (cmd_q.opcode == tst_pkg::OP_BY_TIME)) begin
					load_out = 1'b1;
					out_d    = to_rsp(rdata, tst_pkg::STS_OK, CW'(di_q) == n_q - CW'(1));
				end
			end
			tst_pkg::S_SHIFT: begin
				re    = sh_go;
				raddr = AW'(rd_q - CW'(1));
				we    = dv_q;
				waddr = di_q + AW'(1);
			end
			tst_pkg::S_PLACE: begin
				we    = 1'b1;
				waddr = pos_q[AW-1:0];
				wdata = new_q;
			end
			tst_pkg::S_EMIT: begin
				load_out = out_free;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= tst_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
			n_q         <= '0;
			dv_q        <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (rd_go || sh_go) begin
				dv_q <= 1'b1;
			end else if (cons || (st_q == tst_pkg::S_SHIFT)) begin
				dv_q <= 1'b0;
			end
			if ((st_q == tst_pkg::S_SCAN) && scan_done
					&& (cmd_q.opcode == tst_pkg::OP_DELETE)) begin
				n_q <= kept_q;
			end else if (st_q == tst_pkg::S_PLACE) begin
				n_q <= n_q + CW'(1);
			end
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q <= out_d;
		end
		if (rd_go || sh_go) begin
			di_q <= raddr;
		end
		if (rd_go) begin
			rd_q <= rd_q + CW'(1);
		end else if (sh_go) begin
			rd_q <= rd_q - CW'(1);
		end

		case (st_q)
			tst_pkg::S_IDLE: begin
				cmd_q       <= cmd;
				rd_q        <= '0;
				kept_q      <= '0;
				hit_q       <= 1'b0;
				maxid_q     <= '0;
				pos_found_q <= 1'b0;
				pos_q       <= n_q;
				found_q     <= 1'b0;
				pass_q      <= '0;
				have_last_q <= 1'b0;
				if (cmd.opcode == tst_pkg::OP_INSERT) begin
					pend_q <= to_rsp(cmd_entry(cmd), tst_pkg::STS_FULL, 1'b1);
				end else begin
					pend_q <= to_rsp('0, tst_pkg::STS_NO_MATCH, 1'b1);
				end
			end
			tst_pkg::S_SCAN: begin
				if (cons) begin
					case (cmd_q.opcode)
						tst_pkg::OP_INSERT: begin
							if (rdata.id > maxid_q) begin
								maxid_q <= rdata.id;
							end
							if (!pos_found_q && (time_key(cmd_entry(cmd_q))
									>= time_key(rdata))) begin
								pos_found_q <= 1'b1;
								pos_q       <= CW'(di_q);
							end
						end
						tst_pkg::OP_DELETE: begin
							if (rdata.id == cmd_q.record_id_in) begin
								hit_q <= 1'b1;
							end else begin
								kept_q <= kept_q + CW'(1);
							end
						end
						tst_pkg::OP_MAX, tst_pkg::OP_MIN: begin
							if ({rdata.year, rdata.month, rdata.day, rdata.hour}
									== {cmd_q.year, cmd_q.month, cmd_q.day, cmd_q.hour}) begin
								if (!found_q || ((cmd_q.opcode == tst_pkg::OP_MAX)
										? (rdata.temperature >= best_q.temperature)
										: (rdata.temperature <= best_q.temperature))) begin
									best_q <= rdata;
								end
								found_q <= 1'b1;
							end
						end
						tst_pkg::OP_BY_TEMP: begin
							// candidates come after the last result in sort order
							if (!have_last_q || (rdata.temperature > last_t_q)
									|| ((rdata.temperature == last_t_q)
									&& (di_q < last_idx_q))) begin
								if (!found_q || (rdata.temperature <= best_q.temperature)) begin
									best_q     <= rdata;
									best_idx_q <= di_q;
								end
								found_q <= 1'b1;
							end
						end
						default: ;
					endcase
				end
				if (scan_done) begin
					case (cmd_q.opcode)
						tst_pkg::OP_DELETE: begin
							pend_q <= to_rsp(tst_pkg::entry_t'({48'd0, cmd_q.record_id_in}),
								hit_q ? tst_pkg::STS_OK : tst_pkg::STS_NO_ID, 1'b1);
						end
						tst_pkg::OP_MAX, tst_pkg::OP_MIN: begin
							if (found_q) begin
								pend_q <= to_rsp(best_q, tst_pkg::STS_OK, 1'b1);
							end
						end
						default: ;
					endcase
				end
			end
			tst_pkg::S_DECIDE: begin
				new_q  <= with_id(cmd_entry(cmd_q), (n_q == '0) ? 16'd0 : maxid_q + 16'd1);
				pend_q <= to_rsp(cmd_entry(cmd_q), tst_pkg::STS_IDS_OUT, 1'b1);
				rd_q   <= n_q;
			end
			tst_pkg::S_PLACE: begin
				pend_q <= to_rsp(new_q, tst_pkg::STS_OK, 1'b1);
			end
			tst_pkg::S_EMIT: begin
				if (out_free) begin
					pass_q      <= pass_q + CW'(1);
					have_last_q <= 1'b1;
					last_t_q    <= best_q.temperature;
					last_idx_q  <= best_idx_q;
					found_q     <= 1'b0;
					rd_q        <= '0;
				end
			end
			default: ;
		endcase

		// sort pass result is built at the end of each pass
		if ((st_q == tst_pkg::S_SCAN) && scan_done && (cmd_q.opcode == tst_pkg::OP_BY_TEMP)) begin
			pend_q <= to_rsp(best_q, tst_pkg::STS_OK, pass_q == n_q - CW'(1));
		end
	end

	// the entry count never exceeds the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(TABLE_DEPTH))
		else $error("entry count past table depth");

	// no memory write outside a walk
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == tst_pkg::S_IDLE) |-> !we)
		else $error("memory write while idle");

	// every read stays below the count
	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		re |-> (CW'(raddr) < n_q))
		else $error("read past entry count");

	// placing a new entry grows the table by one
	a_place_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == tst_pkg::S_PLACE) |=> (n_q == $past(n_q) + CW'(1)))
		else $error("insert did not grow the table");

endmodule

// ===== design/tst_ram.sv =====
// generic single write port, single read port memory with registered read
// read data holds while no read is issued
// no dependencies
module tst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sim/tst_checker.sv =====
// result checker for the timestamped sample table
// predicts every result from the accepted requests and compares field by field
// depends on tst_pkg
`timescale 1ns / 1ps
module tst_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_stall,
	input  tst_pkg::cmd_t cmd,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  tst_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending
);
	import tst_pkg::*;

	entry_t       table_q [$];
	rsp_t         expected_rsp [$];

	// key ordered like the timestamp, minute included
	function automatic logic [31:0] stamp_key(entry_t e);
		return {e.year, e.month, e.day, e.hour, e.minute};
	endfunction

	function automatic rsp_t entry_rsp(logic [2:0] st, entry_t e, logic lst);
		rsp_t r;
		r.status = st;
		r.out_id = e.id;
		r.out_temperature = e.temperature;
		r.out_year = e.year;
		r.out_month = e.month;
		r.out_day = e.day;
		r.out_hour = e.hour;
		r.out_minute = e.minute;
		r.last = lst;
		return r;
	endfunction

	// apply one request to the shadow table and queue its results
	task automatic predict_request(cmd_t c);
		entry_t s, z;
		logic [15:0] maxid;
		int pos, best, n, j;
		int order [$];
		bit hit;
		entry_t kept [$];
		rsp_t r;
		z = '0;
		s = '0;
		s.temperature = c.temperature;
		s.year = c.year;
		s.month = c.month;
		s.day = c.day;
		s.hour = c.hour;
		s.minute = c.minute;
		n = table_q.size();
		case (c.opcode)
			OP_INSERT: begin
				maxid = 0;
				foreach (table_q[i]) if (table_q[i].id > maxid) maxid = table_q[i].id;
				if (n >= TableDepth) expected_rsp.push_back(entry_rsp(STS_FULL, s, 1'b1));
				else if (n > 0 && maxid == MaxId)
					expected_rsp.push_back(entry_rsp(STS_IDS_OUT, s, 1'b1));
				else begin
					s.id = (n == 0) ? 16'd0 : maxid + 16'd1;
					pos = n;
					for (int i = 0; i < n; i++)
						if (stamp_key(s) >= stamp_key(table_q[i])) begin
							pos = i;
							break;
						end
					table_q.insert(pos, s);
					expected_rsp.push_back(entry_rsp(STS_OK, s, 1'b1));
				end
			end
			OP_DELETE: begin
				hit = 0;
				foreach (table_q[i])
					if (table_q[i].id == c.record_id_in) hit = 1;
					else kept.push_back(table_q[i]);
				table_q = kept;
				z.id = c.record_id_in;
				expected_rsp.push_back(entry_rsp(hit ? STS_OK : STS_NO_ID, z, 1'b1));
			end
			OP_MAX, OP_MIN: begin
				best = -1;
				foreach (table_q[i]) begin
					if (stamp_key(table_q[i]) >> 6 != stamp_key(s) >> 6) continue;
					if (best < 0) best = i;
					else if (c.opcode == OP_MAX ?
							table_q[i].temperature >= table_q[best].temperature :
							table_q[i].temperature <= table_q[best].temperature)
						best = i;
				end
				if (best < 0) expected_rsp.push_back(entry_rsp(STS_NO_MATCH, z, 1'b1));
				else expected_rsp.push_back(entry_rsp(STS_OK, table_q[best], 1'b1));
			end
			OP_BY_TIME, OP_BY_TEMP: begin
				if (n == 0) expected_rsp.push_back(entry_rsp(STS_NO_MATCH, z, 1'b1));
				else begin
					for (int i = 0; i < n; i++)
						order.push_back(c.opcode == OP_BY_TIME ? i : n - 1 - i);
					// stable insertion sort by signed temperature
					if (c.opcode == OP_BY_TEMP)
						for (int i = 1; i < n; i++) begin
							pos = order[i];
							j = i;
							while (j > 0 && table_q[order[j-1]].temperature >
									table_q[pos].temperature) begin
								order[j] = order[j-1];
								j--;
							end
							order[j] = pos;
						end
					for (int i = 0; i < n; i++)
						expected_rsp.push_back(entry_rsp(STS_OK, table_q[order[i]], i == n - 1));
				end
			end
			default: ;
		endcase
	endtask

	assign pending = expected_rsp.size();

	// watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$error("unexpected result %p", rsp);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_rsp.pop_front();
					if (e !== rsp) begin
						fail_count <= fail_count + 1;
						if (e.status !== rsp.status)
							$error("status exp %0d got %0d", e.status, rsp.status);
						if (e.out_id !== rsp.out_id)
							$error("out_id exp %0d got %0d", e.out_id, rsp.out_id);
						if (e.out_temperature !== rsp.out_temperature)
							$error("out_temperature exp %0d got %0d",
								e.out_temperature, rsp.out_temperature);
						if (e.out_year !== rsp.out_year)
							$error("out_year exp %0d got %0d", e.out_year, rsp.out_year);
						if (e.out_month !== rsp.out_month)
							$error("out_month exp %0d got %0d", e.out_month, rsp.out_month);
						if (e.out_day !== rsp.out_day)
							$error("out_day exp %0d got %0d", e.out_day, rsp.out_day);
						if (e.out_hour !== rsp.out_hour)
							$error("out_hour exp %0d got %0d", e.out_hour, rsp.out_hour);
						if (e.out_minute !== rsp.out_minute)
							$error("out_minute exp %0d got %0d", e.out_minute, rsp.out_minute);
						if (e.last !== rsp.last)
							$error("last exp %0d got %0d", e.last, rsp.last);
					end
				end
			end
			if (cmd_valid && !cmd_stall) predict_request(cmd);
		end
	end
endmodule

// ===== sim/tb_top.sv =====
// testbench top for the timestamped sample table
// drives directed and random requests with bursty idling and random result stalls
// depends on tst_pkg, tst_checker and the design
`timescale 1ns / 1ps
module tb_top;
	import tst_pkg::*;

	localparam int IdleLimit = 200000;

	logic  clk, arst_n, cmd_valid, cmd_stall, rsp_valid, rsp_stall;
	cmd_t  cmd;
	rsp_t  rsp;
	int    fail_count, pending, idle_cycles;
	bit    stall_mode;
	logic [15:0] id_pool [$];

	timestamped_sample_table dut (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.cmd(cmd), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	tst_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.cmd(cmd), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// receiver stall pattern: quiet stretches and busy stretches
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
		rsp_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// hand one request over and wait for it to be taken
	task automatic send_request(cmd_t c);
		@(negedge clk);
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		@(negedge clk);
		cmd_valid <= 1'b0;
	endtask

	function automatic cmd_t make_sample(logic [2:0] op);
		cmd_t c;
		c.opcode = op;
		c.year = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(2020, 2021));
		c.month = 4'($urandom_range(1, 12));
		c.day = 5'($urandom_range(1, 31));
		c.hour = 5'($urandom_range(0, 23));
		c.minute = 6'($urandom_range(0, 59));
		c.temperature = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
		c.record_id_in = 16'($urandom);
		return c;
	endfunction

	task automatic gap();
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	initial begin
		cmd_t c;
		int burst;
		bit drained;
		arst_n = 0;
		cmd_valid = 0;
		cmd = '0;
		drained = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// empty table cases
		for (int op = 1; op <= 5; op++) begin
			c = make_sample(op[2:0]);
			send_request(c);
		end
		// extremes of the fields, equal timestamps and temperatures
		c = make_sample(OP_INSERT);
		c.year = 0; c.month = 1; c.day = 1; c.hour = 0; c.minute = 0; c.temperature = 16'sh8000;
		send_request(c);
		c.year = 12'hFFF; c.month = 12; c.day = 31; c.hour = 23; c.minute = 59;
		c.temperature = 16'sh7FFF;
		send_request(c);
		send_request(c);
		c.minute = 0; c.temperature = 16'sh7FFF;
		send_request(c);
		c.opcode = OP_MAX; send_request(c);
		c.opcode = OP_MIN; send_request(c);
		c.opcode = OP_BY_TIME; send_request(c);
		c.opcode = OP_BY_TEMP; send_request(c);
		c.opcode = 3'd6; send_request(c);
		c.opcode = 3'd7; send_request(c);
		c.opcode = OP_DELETE; c.record_id_in = 16'd2; send_request(c);
		c.record_id_in = 16'hFFFF; send_request(c);
		c.record_id_in = 16'd0; send_request(c);
		c.opcode = OP_BY_TIME; send_request(c);
		// id wraps toward the top: delete down to one, then raise ids one step at a time is
		// too slow, so drain and fill to the full table instead
		wait (pending == 0);
		repeat (40) @(negedge clk);
		for (int i = 0; i < 66; i++) begin
			c = make_sample(OP_INSERT);
			send_request(c);
		end
		c.opcode = OP_BY_TEMP; send_request(c);
		for (int i = 0; i < 70; i++) begin
			c = make_sample(OP_DELETE);
			c.record_id_in = 16'(i);
			send_request(c);
		end

		// random part, mostly inserts with some deletes of live ids
		for (int n = 0; n < 75; ) begin
			burst = $urandom_range(1, 8);
			repeat (burst) begin
				case ($urandom_range(0, 15))
					0, 1, 2, 3, 4, 5, 6: c = make_sample(OP_INSERT);
					7, 8, 9: begin
						c = make_sample(OP_DELETE);
						if ($urandom_range(0, 3) != 0) c.record_id_in = 16'($urandom_range(0, 70));
					end
					10, 11: c = make_sample(OP_MAX);
					12: c = make_sample(OP_MIN);
					13: c = make_sample(OP_BY_TIME);
					14: c = make_sample(OP_BY_TEMP);
					default: c = make_sample(3'($urandom_range(6, 7)));
				endcase
				send_request(c);
				if (c.opcode <= OP_BY_TEMP) n++;
			end
			gap();
			if (!drained && n >= 40) begin
				drained = 1;
				wait (pending == 0);
				repeat (20) @(negedge clk);
			end
		end

		wait (pending == 0);
		repeat (300) @(negedge clk);
		if (fail_count == 0 && pending == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
